>>> sv/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and constants for the calendar day difference block
// Transaction structs, field widths, year limit and calendar look-up functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int YY_W     = YEAR_W + 1;   // year shifted by 400
    localparam int QUOT_W   = 8;            // year / 100 for any shifted year up to 10399
    localparam int SERIAL_W = 23;
    localparam int DIFF_W   = 23;
    localparam int MOFF_W   = 9;

    localparam logic [YEAR_W-1:0] MAX_YEAR  = 14'd9999;
    localparam logic [YY_W-1:0]   YEAR_BIAS = 15'd400;

    // y / 100 == (y * RECIP_100) >> RECIP_SHIFT, exact for y below 43699
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic signed [DIFF_W-1:0] DIFF_MAX = 23'sh3FFFFF;
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = 23'sh400000;

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        logic               include_end_day;
    } t_cdd_req;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     invalid_date;
    } t_cdd_rsp;

    // result of one date lane
    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic                ok;
    } t_cdd_lane;

    // days from March 1 to the first of the month, year starting in March
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] off;
        case (m)
            MONTH_MAR: off = 9'd0;
            MONTH_APR: off = 9'd31;
            MONTH_MAY: off = 9'd61;
            MONTH_JUN: off = 9'd92;
            MONTH_JUL: off = 9'd122;
            MONTH_AUG: off = 9'd153;
            MONTH_SEP: off = 9'd184;
            MONTH_OCT: off = 9'd214;
            MONTH_NOV: off = 9'd245;
            MONTH_DEC: off = 9'd275;
            MONTH_JAN: off = 9'd306;
            MONTH_FEB: off = 9'd337;
            default:   off = 9'd0;
        endcase
        return off;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> sv/cdd_lane.sv
// ----------------------------------------------------------------------------
// cdd_lane: date check and day serial number, three register stages
// Stage 1 divides years by 100, stage 2 finds the leap year and scales the
// year, stage 3 checks the day against the month length and sums the serial.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_lane (
    input  wire logic                        i_clk,
    input  wire logic [cdd_pkg::DAY_W-1:0]   i_day,
    input  wire logic [cdd_pkg::MONTH_W-1:0] i_month,
    input  wire logic [cdd_pkg::YEAR_W-1:0]  i_year,
    output cdd_pkg::t_cdd_lane               o_lane
);

    // stage 1
    logic [cdd_pkg::YY_W-1:0]    n1_yy;
    logic [26:0]                 n1_prod_y;
    logic [27:0]                 n1_prod_yy;
    logic [cdd_pkg::DAY_W-1:0]   r1_day;
    logic [cdd_pkg::MONTH_W-1:0] r1_month;
    logic [cdd_pkg::YEAR_W-1:0]  r1_year;
    logic [cdd_pkg::YY_W-1:0]    r1_yy;
    logic [cdd_pkg::QUOT_W-1:0]  r1_q_y;
    logic [cdd_pkg::QUOT_W-1:0]  r1_q_yy;
    logic [cdd_pkg::MOFF_W-1:0]  r1_moff;
    logic                        r1_fmt_ok;

    // stage 2
    logic [cdd_pkg::YEAR_W-1:0]   n2_hund;
    logic [cdd_pkg::YEAR_W-1:0]   n2_rem;
    logic [cdd_pkg::DAY_W-1:0]    r2_day;
    logic [cdd_pkg::MONTH_W-1:0]  r2_month;
    logic                         r2_leap;
    logic                         r2_fmt_ok;
    logic [cdd_pkg::SERIAL_W-1:0] r2_yy365;
    logic [cdd_pkg::SERIAL_W-1:0] r2_base;

    // stage 3
    logic [cdd_pkg::DAY_W-1:0]    n3_len;
    logic [cdd_pkg::SERIAL_W-1:0] r3_serial;
    logic                         r3_ok;

    assign n1_yy = {1'b0, i_year} + cdd_pkg::YEAR_BIAS
                 - ((i_month <= cdd_pkg::MONTH_FEB) ? 15'd1 : 15'd0);
    assign n1_prod_y  = 27'(i_year) * 27'(cdd_pkg::RECIP_100);
    assign n1_prod_yy = 28'(n1_yy) * 28'(cdd_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        r1_day    <= i_day;
        r1_month  <= i_month;
        r1_year   <= i_year;
        r1_yy     <= n1_yy;
        r1_q_y    <= n1_prod_y[cdd_pkg::RECIP_SHIFT +: cdd_pkg::QUOT_W];
        r1_q_yy   <= n1_prod_yy[cdd_pkg::RECIP_SHIFT +: cdd_pkg::QUOT_W];
        r1_moff   <= cdd_pkg::month_offset(i_month);
        r1_fmt_ok <= (i_month >= cdd_pkg::MONTH_JAN) && (i_month <= cdd_pkg::MONTH_DEC)
                  && (i_year <= cdd_pkg::MAX_YEAR);
    end

    assign n2_hund = 14'(r1_q_y) * 14'd100;
    assign n2_rem  = r1_year - n2_hund;

    always_ff @(posedge i_clk) begin
        r2_day    <= r1_day;
        r2_month  <= r1_month;
        r2_fmt_ok <= r1_fmt_ok;
        r2_leap   <= (r1_year[1:0] == 2'd0) && ((n2_rem != '0) || (r1_q_y[1:0] == 2'd0));
        r2_yy365  <= 23'(r1_yy) * 23'd365;
        // a bad day of zero gives one day below the first of the month; such a date is flagged invalid anyway
        r2_base   <= 23'(r1_yy >> 2) + 23'(r1_q_yy >> 2) - 23'(r1_q_yy)
                   + 23'(r1_moff) + 23'(r1_day) - 23'd1;
    end

    assign n3_len = cdd_pkg::month_length(r2_month, r2_leap);

    always_ff @(posedge i_clk) begin
        r3_serial <= r2_yy365 + r2_base;
        r3_ok     <= r2_fmt_ok && (r2_day != '0) && (r2_day <= n3_len);
    end

    assign o_lane.serial = r3_serial;
    assign o_lane.ok     = r3_ok;

endmodule

`default_nettype wire

>>> sv/calendar_day_difference.sv
// ----------------------------------------------------------------------------
// calendar_day_difference: signed day count between two Gregorian dates
// Two date lanes feed a subtract stage and a sign and clamp stage.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_cmd and pulse start; the transaction is taken at a rising edge
//   with start high and busy low. busy is high only while i_rst_n is low,
//   so a new transaction may be issued in every cycle.
//   The result appears on o_rsp with o_strobe high for exactly one cycle,
//   in issue order. The path has three stages in each date lane, one for
//   the difference, and one for sign, end-day adjustment and clamp.
//   Throughput: one transaction per cycle, set by the fully pipelined lanes.
//   A date with a bad month, a bad day or a year past the limit gives
//   invalid_date set and a difference of zero. Equal dates count as not
//   before, so they give zero, or minus one with include_end_day set.
//   Reset clears the valid bits of all stages; nothing is in flight after.
//   The receiver cannot stall: o_strobe marks a result that must be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_day_difference (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cdd_pkg::t_cdd_req i_cmd,
    output logic                   o_strobe,
    output cdd_pkg::t_cdd_rsp      o_rsp
);

    cdd_pkg::t_cdd_lane first_lane;
    cdd_pkg::t_cdd_lane second_lane;

    logic n_take;
    logic r_v1, r_v2, r_v3, r_v4, r_vout;
    logic r_incl1, r_incl2, r_incl3, r_incl4;

    logic                          r4_neg;
    logic                          r4_bad;
    logic [cdd_pkg::SERIAL_W-1:0]  r4_mag;

    logic [cdd_pkg::SERIAL_W:0]    n5_mag;
    logic signed [cdd_pkg::DIFF_W-1:0] n5_res;
    cdd_pkg::t_cdd_rsp             r_rsp;

    assign busy   = !i_rst_n;
    assign n_take = start && !busy;

    cdd_lane u_first (
        .i_clk   (i_clk),
        .i_day   (i_cmd.first_day),
        .i_month (i_cmd.first_month),
        .i_year  (i_cmd.first_year),
        .o_lane  (first_lane)
    );

    cdd_lane u_second (
        .i_clk   (i_clk),
        .i_day   (i_cmd.second_day),
        .i_month (i_cmd.second_month),
        .i_year  (i_cmd.second_year),
        .o_lane  (second_lane)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            r_v1   <= n_take;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_vout <= r_v4;
        end
    end

    // carry the end-day flag alongside the lanes
    always_ff @(posedge i_clk) begin
        r_incl1 <= i_cmd.include_end_day;
        r_incl2 <= r_incl1;
        r_incl3 <= r_incl2;
        r_incl4 <= r_incl3;
    end

    // difference stage: equal dates take the negative side
    always_ff @(posedge i_clk) begin
        r4_neg <= second_lane.serial <= first_lane.serial;
        r4_mag <= (second_lane.serial <= first_lane.serial)
                ? first_lane.serial - second_lane.serial
                : second_lane.serial - first_lane.serial;
        r4_bad <= !(first_lane.ok && second_lane.ok);
    end

    assign n5_mag = {1'b0, r4_mag} + {23'd0, r_incl4};

    always_comb begin
        if (r4_bad) begin
            n5_res = '0;
        end else if (r4_neg) begin
            if (n5_mag > 24'd4194304) begin
                n5_res = cdd_pkg::DIFF_MIN;
            end else begin
                n5_res = -$signed(n5_mag[cdd_pkg::DIFF_W-1:0]);
            end
        end else begin
            if (n5_mag > 24'd4194303) begin
                n5_res = cdd_pkg::DIFF_MAX;
            end else begin
                n5_res = $signed(n5_mag[cdd_pkg::DIFF_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp.day_difference <= n5_res;
        r_rsp.invalid_date   <= r4_bad;
    end

    assign o_strobe = r_vout;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire
